[src/swrb_pkg.sv]
// Shared constants, command and status types of the sliding window retransmit buffer.
package swrb_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int MAX_PACKET = 2048;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int OFF_W      = $clog2(MAX_PACKET);
    localparam int LEN_W      = OFF_W + 1;
    localparam int WS_W       = 7;
    localparam int SEQ_W      = 32;
    localparam int PKT_AW     = IDX_W + OFF_W;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = SEQ_W / DIV_BITS;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam logic [2:0] OP_WRITE   = 3'd0;
    localparam logic [2:0] OP_DELETE  = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_SLIDE   = 3'd3;
    localparam logic [2:0] OP_ADVANCE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CONFLICT = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic load_item;
        logic div_run;
        logic exec;
        logic slide_run;
        logic slide_end;
        logic finish;
        logic cfg_write;
    } swrb_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       div_last;
        logic       slide_last;
        logic       out_free;
    } swrb_stat_t;

endpackage

[src/swrb_ram.sv]
// Generic single write port RAM with a registered read port.
module swrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/swrb_ctrl.sv]
// Controller state machine of the sliding window retransmit buffer.
module swrb_ctrl import swrb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  swrb_stat_t stat,
    output swrb_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_SLIDE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.cfg_write = cfg_valid;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_run = 1'b1;
                if (stat.div_last)
                begin
                    if (stat.op == OP_SLIDE)
                    begin
                        state_next = S_SLIDE;
                    end
                    else if (stat.op inside {OP_WRITE, OP_DELETE, OP_READ})
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
            end
            S_SLIDE:
            begin
                if (stat.slide_last)
                begin
                    cmd.slide_end = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.slide_run = 1'b1;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/swrb_dp.sv]
// Datapath: slot table, packet memory, modulo unit, edges and output register.
module swrb_dp import swrb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  swrb_cmd_t          cmd,
    output swrb_stat_t         stat,
    input  logic [WS_W-1:0]    window_size,
    input  logic [2:0]         opcode,
    input  logic [SEQ_W-1:0]   seq_num,
    input  logic [OFF_W-1:0]   byte_offset,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic [WS_W-1:0]    shift_amount,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [1:0]         status,
    output logic [7:0]         read_byte,
    output logic [LEN_W-1:0]   entry_length,
    output logic               entry_filled,
    output logic [SEQ_W-1:0]   lower_edge,
    output logic [SEQ_W-1:0]   current_edge,
    output logic [SEQ_W-1:0]   upper_edge,
    output logic [WS_W-1:0]    item_count,
    output logic               window_open
);

    // Item registers.
    logic [2:0]       op_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic [OFF_W-1:0] off_reg;
    logic [7:0]       data_reg;
    logic             last_reg;
    logic [WS_W-1:0]  shift_reg;

    // Window state.
    logic [WS_W-1:0]       ws_reg, ws_next;
    logic [MAX_WINDOW-1:0] filled_reg, filled_next;
    logic [WS_W-1:0]       count_reg, count_next;
    logic [SEQ_W-1:0]      lower_reg, lower_next;
    logic [SEQ_W-1:0]      current_reg, current_next;
    logic [SEQ_W-1:0]      upper_reg, upper_next;

    // Modulo unit and slot pointer.
    logic [SEQ_W-1:0]  word_reg, word_next;
    logic [WS_W-1:0]   rem_reg, rem_next;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [WS_W-1:0]   scnt_reg;

    // Result and output registers.
    logic [1:0]       res_status_reg, res_status_next;
    logic [7:0]       res_byte_reg, res_byte_next;
    logic [LEN_W-1:0] res_len_reg, res_len_next;
    logic             res_fill_reg, res_fill_next;
    logic             out_valid_reg;
    logic [1:0]       o_status_reg;
    logic [7:0]       o_byte_reg;
    logic [LEN_W-1:0] o_len_reg;
    logic             o_fill_reg;
    logic [SEQ_W-1:0] o_lower_reg, o_current_reg, o_upper_reg;
    logic [WS_W-1:0]  o_count_reg;
    logic             o_open_reg;

    // Memories.
    logic                   slot_we;
    logic [SEQ_W+LEN_W-1:0] slot_wdata, slot_rdata;
    logic                   pkt_we;
    logic [7:0]             pkt_rdata;
    logic [PKT_AW-1:0]      pkt_addr;
    logic [SEQ_W-1:0]       rd_seq;
    logic [LEN_W-1:0]       rd_len;

    logic [WS_W-1:0]  eff_ws, eff_cfg;
    logic             filled_cur, conflict, store_last;
    logic [LEN_W-1:0] new_len;
    logic [SEQ_W-1:0] slide_lower;

    function automatic logic [WS_W-1:0] clamp_ws(input logic [WS_W-1:0] ws);
        if (ws == '0)
        begin
            return WS_W'(1);
        end
        else if (ws > WS_W'(MAX_WINDOW))
        begin
            return WS_W'(MAX_WINDOW);
        end
        return ws;
    endfunction

    function automatic logic is_before(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d[SEQ_W-1];
    endfunction

    assign eff_ws  = clamp_ws(ws_reg);
    assign eff_cfg = clamp_ws(window_size);

    swrb_ram #(.WIDTH(SEQ_W + LEN_W), .DEPTH(MAX_WINDOW)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (ptr_reg),
        .wdata (slot_wdata),
        .raddr (ptr_reg),
        .rdata (slot_rdata)
    );

    swrb_ram #(.WIDTH(8), .DEPTH(MAX_WINDOW * MAX_PACKET)) u_pkt_ram (
        .clk   (clk),
        .we    (pkt_we),
        .waddr (pkt_addr),
        .wdata (data_reg),
        .raddr (pkt_addr),
        .rdata (pkt_rdata)
    );

    assign pkt_addr = {ptr_reg, off_reg};
    assign rd_seq   = slot_rdata[SEQ_W+LEN_W-1:LEN_W];
    assign rd_len   = slot_rdata[LEN_W-1:0];

    // Slot decisions for the item under execution.
    assign filled_cur = filled_reg[ptr_reg];
    assign conflict   = filled_cur && (rd_seq != seq_reg);
    assign new_len    = {1'b0, off_reg} + LEN_W'(1);
    assign store_last = cmd.exec && (op_reg == OP_WRITE) && !conflict && last_reg;
    assign pkt_we     = cmd.exec && (op_reg == OP_WRITE) && !conflict;
    assign slot_we    = store_last;
    assign slot_wdata = {seq_reg, new_len};
    assign slide_lower = lower_reg + SEQ_W'(shift_reg);

    // Modulo unit: DIV_BITS restoring steps per cycle.
    always_comb
    begin
        logic [WS_W-1:0] r;
        logic [SEQ_W-1:0] w;
        r = rem_reg;
        w = word_reg;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            r = {r[WS_W-2:0], w[SEQ_W-1]};
            w = {w[SEQ_W-2:0], 1'b0};
            if (r >= eff_ws)
            begin
                r = r - eff_ws;
            end
        end
        rem_next  = r;
        word_next = w;
    end

    // Window state and results.
    always_comb
    begin
        ws_next         = ws_reg;
        filled_next     = filled_reg;
        count_next      = count_reg;
        lower_next      = lower_reg;
        current_next    = current_reg;
        upper_next      = upper_reg;
        ptr_next        = ptr_reg;
        res_status_next = res_status_reg;
        res_byte_next   = res_byte_reg;
        res_len_next    = res_len_reg;
        res_fill_next   = res_fill_reg;

        if (cmd.cfg_write)
        begin
            ws_next      = window_size;
            filled_next  = '0;
            count_next   = '0;
            lower_next   = '0;
            current_next = '0;
            upper_next   = SEQ_W'(eff_cfg);
        end

        if (cmd.load_item)
        begin
            res_status_next = ST_OK;
            res_byte_next   = '0;
            res_len_next    = '0;
            res_fill_next   = 1'b0;
        end

        if (cmd.div_run && stat.div_last)
        begin
            ptr_next = rem_next[IDX_W-1:0];
        end

        if (cmd.exec)
        begin
            case (op_reg)
                OP_WRITE:
                begin
                    if (conflict)
                    begin
                        res_status_next = ST_CONFLICT;
                    end
                    if (store_last)
                    begin
                        filled_next[ptr_reg] = 1'b1;
                        if (!filled_cur)
                        begin
                            count_next = count_reg + WS_W'(1);
                        end
                        res_len_next  = new_len;
                        res_fill_next = 1'b1;
                    end
                    else if (filled_cur)
                    begin
                        res_len_next  = rd_len;
                        res_fill_next = 1'b1;
                    end
                end
                OP_DELETE:
                begin
                    filled_next[ptr_reg] = 1'b0;
                    if (filled_cur)
                    begin
                        count_next = count_reg - WS_W'(1);
                    end
                end
                OP_READ:
                begin
                    if (!filled_cur)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        res_len_next  = rd_len;
                        res_fill_next = 1'b1;
                        if (rd_seq != seq_reg)
                        begin
                            res_status_next = ST_CONFLICT;
                        end
                        else if ({1'b0, off_reg} < rd_len)
                        begin
                            res_byte_next = pkt_rdata;
                        end
                    end
                end
                OP_ADVANCE:
                begin
                    current_next = current_reg + SEQ_W'(shift_reg);
                end
                default:
                begin
                end
            endcase
        end

        // One slot leaves the window per cycle.
        if (cmd.slide_run)
        begin
            filled_next[ptr_reg] = 1'b0;
            if (filled_cur)
            begin
                count_next = count_reg - WS_W'(1);
            end
            if ({1'b0, ptr_reg} == eff_ws - WS_W'(1))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + IDX_W'(1);
            end
        end

        if (cmd.slide_end)
        begin
            lower_next = slide_lower;
            upper_next = upper_reg + SEQ_W'(shift_reg);
            if (is_before(current_reg, slide_lower))
            begin
                current_next = slide_lower;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= WS_W'(MAX_WINDOW);
            filled_reg    <= '0;
            count_reg     <= '0;
            lower_reg     <= '0;
            current_reg   <= '0;
            upper_reg     <= SEQ_W'(MAX_WINDOW);
            dcnt_reg      <= '0;
            scnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ws_reg      <= ws_next;
            filled_reg  <= filled_next;
            count_reg   <= count_next;
            lower_reg   <= lower_next;
            current_reg <= current_next;
            upper_reg   <= upper_next;
            if (cmd.load_item)
            begin
                dcnt_reg <= '0;
                scnt_reg <= '0;
            end
            else
            begin
                if (cmd.div_run)
                begin
                    dcnt_reg <= dcnt_reg + DCNT_W'(1);
                end
                if (cmd.slide_run)
                begin
                    scnt_reg <= scnt_reg + WS_W'(1);
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        res_len_reg    <= res_len_next;
        res_fill_reg   <= res_fill_next;
        if (cmd.load_item)
        begin
            op_reg    <= opcode;
            seq_reg   <= seq_num;
            off_reg   <= byte_offset;
            data_reg  <= data_byte;
            last_reg  <= last_byte;
            shift_reg <= shift_amount;
            word_reg  <= (opcode == OP_SLIDE) ? lower_reg : seq_num;
            rem_reg   <= '0;
        end
        else if (cmd.div_run)
        begin
            word_reg <= word_next;
            rem_reg  <= rem_next;
        end
        if (cmd.finish)
        begin
            o_status_reg  <= res_status_reg;
            o_byte_reg    <= res_byte_reg;
            o_len_reg     <= res_len_reg;
            o_fill_reg    <= res_fill_reg;
            o_lower_reg   <= lower_reg;
            o_current_reg <= current_reg;
            o_upper_reg   <= upper_reg;
            o_count_reg   <= count_reg;
            o_open_reg    <= is_before(current_reg, upper_reg);
        end
    end

    assign stat.op         = op_reg;
    assign stat.div_last   = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
    assign stat.slide_last = (scnt_reg == shift_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign status       = o_status_reg;
    assign read_byte    = o_byte_reg;
    assign entry_length = o_len_reg;
    assign entry_filled = o_fill_reg;
    assign lower_edge   = o_lower_reg;
    assign current_edge = o_current_reg;
    assign upper_edge   = o_upper_reg;
    assign item_count   = o_count_reg;
    assign window_open  = o_open_reg;

endmodule

[src/sliding_window_retransmit_buffer.sv]
// Top level of the sliding window retransmit buffer.
// Usage: items enter on the in_valid/in_ready channel (opcode, seq_num, byte_offset,
// data_byte, last_byte, shift_amount) and each gives exactly one result item on the
// out_valid/out_ready channel. The window size is written on cfg_valid/cfg_ready with
// cfg_data; a write empties every slot and resets the edges, and is taken only while
// the block is idle.
// Every item first passes the modulo unit (4 quotient bits per cycle over the 32-bit
// operand). Write, delete and read then pass the registered memory read state and the
// execution state; advance and unused opcodes go straight to execution. A slide clears
// shift_amount slots, one slot cleared per cycle, then moves the edges. A new item is
// accepted the cycle after the result is loaded into the output register.
// Reset leaves all slots empty, lower and current at 0 and upper at 64; no clearing
// pass is needed. When the receiver stalls the result waits in the output register
// and the next item is still accepted; that item then holds in its final cycle
// until the output register is free.
module sliding_window_retransmit_buffer import swrb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         opcode,
    input  logic [SEQ_W-1:0]   seq_num,
    input  logic [OFF_W-1:0]   byte_offset,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic [WS_W-1:0]    shift_amount,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [7:0]         read_byte,
    output logic [LEN_W-1:0]   entry_length,
    output logic               entry_filled,
    output logic [SEQ_W-1:0]   lower_edge,
    output logic [SEQ_W-1:0]   current_edge,
    output logic [SEQ_W-1:0]   upper_edge,
    output logic [WS_W-1:0]    item_count,
    output logic               window_open,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WS_W-1:0]    cfg_data
);

    swrb_cmd_t  cmd;
    swrb_stat_t stat;

    swrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    swrb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .window_size  (cfg_data),
        .opcode       (opcode),
        .seq_num      (seq_num),
        .byte_offset  (byte_offset),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .shift_amount (shift_amount),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .status       (status),
        .read_byte    (read_byte),
        .entry_length (entry_length),
        .entry_filled (entry_filled),
        .lower_edge   (lower_edge),
        .current_edge (current_edge),
        .upper_edge   (upper_edge),
        .item_count   (item_count),
        .window_open  (window_open)
    );

    // The count never exceeds the number of slots.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (item_count <= WS_W'(MAX_WINDOW)))
        else $error("item count beyond window");

    // An empty slot reports no entry.
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (!entry_filled && entry_length == '0))
        else $error("empty slot reports an entry");

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && !cfg_ready))
        else $error("input ready again right after acceptance");

endmodule
